// ===== rtl/core/fft_pkg.sv =====
package fft_pkg;

  localparam int MaxLog2 = 6;
  localparam int MaxPoints = 64;
  localparam int AddrW = 6;
  localparam int DataW = 24;
  localparam int TwW = 19;
  localparam int TwFrac = 17;

  localparam logic [2:0] RegSizeLog2 = 3'd0;
  localparam logic [2:0] RegInverse = 3'd1;

  typedef struct packed {
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] bin_re;
    logic signed [23:0] bin_im;
    logic last_out;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic wr_load;
    logic [AddrW-1:0] load_addr;
    logic rd_en;
    logic [AddrW-1:0] rd_addr;
    logic sel_b;
    logic [5:0] tw_idx;
    logic bfly;
    logic wr_a;
    logic wr_b;
    logic swap;
    logic [AddrW-1:0] addr_a;
    logic [AddrW-1:0] addr_b;
    logic zero_wr;
    logic [2:0] shift;
  } fft_cmd_t;

  // Quarter-wave cosine, Q1.17.
  function automatic logic signed [TwW-1:0] cos_q(input logic [4:0] r);
    case (r)
      5'd0: cos_q = 19'sd131072;
      5'd1: cos_q = 19'sd130441;
      5'd2: cos_q = 19'sd128553;
      5'd3: cos_q = 19'sd125428;
      5'd4: cos_q = 19'sd121095;
      5'd5: cos_q = 19'sd115595;
      5'd6: cos_q = 19'sd108982;
      5'd7: cos_q = 19'sd101320;
      5'd8: cos_q = 19'sd92682;
      5'd9: cos_q = 19'sd83151;
      5'd10: cos_q = 19'sd72820;
      5'd11: cos_q = 19'sd61787;
      5'd12: cos_q = 19'sd50159;
      5'd13: cos_q = 19'sd38048;
      5'd14: cos_q = 19'sd25571;
      5'd15: cos_q = 19'sd12847;
      default: cos_q = 19'sd0;
    endcase
  endfunction

  function automatic logic signed [TwW-1:0] rom_cos(input logic [5:0] t);
    logic [4:0] r;
    logic [4:0] rc;
    r = {1'b0, t[3:0]};
    rc = 5'd16 - r;
    case (t[5:4])
      2'd0: rom_cos = cos_q(r);
      2'd1: rom_cos = -cos_q(rc);
      2'd2: rom_cos = -cos_q(r);
      default: rom_cos = cos_q(rc);
    endcase
  endfunction

endpackage

// ===== rtl/core/radix2_fft_engine.sv =====
// Radix-2 DIT FFT, one shared butterfly over a 64-entry work store, one block at a time.
// Load: one sample per cycle; in_stall stays high from the last sample until the last bin.
// Transform: zero the unfilled entries, swap each bit-reversed pair (read, read, latch, write back
// crossed), run (n/2)*log2(n) butterflies (read A, read B, multiply, write), then drain the n bins.
// Synchronous active-low reset: size_log2 = 6, inverse = 0, load count zero, output empty.
module radix2_fft_engine
  import fft_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_item_t out_data,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [2:0] cfg_wdata
);

  logic [2:0] size_log2_r;
  logic inverse_r;
  logic in_ready, in_fire, push, last;
  logic signed [DataW-1:0] rd_re, rd_im;
  fft_cmd_t cmd;
  logic out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_log2_r <= 3'd6;
      inverse_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegSizeLog2: size_log2_r <= cfg_wdata;
        RegInverse: inverse_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_stall = !in_ready;
  assign in_fire = in_valid && in_ready;
  assign out_busy = out_valid && out_stall;

  fft_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_last(in_data.last_in),
    .size_log2(size_log2_r), .inverse(inverse_r), .out_busy(out_busy),
    .in_ready(in_ready), .out_push(push), .out_last(last), .cmd(cmd)
  );

  fft_dpath u_dp (
    .clk(clk), .in_item(in_data), .inverse(inverse_r), .cmd(cmd),
    .rd_re(rd_re), .rd_im(rd_im)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (!out_busy) begin
      out_valid <= push;
      out_data.bin_re <= rd_re;
      out_data.bin_im <= rd_im;
      out_data.last_out <= last;
    end
  end

endmodule

// ===== rtl/core/fft_ctrl.sv =====
module fft_ctrl
  import fft_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic in_last,
  input  logic [2:0] size_log2,
  input  logic inverse,
  input  logic out_busy,
  output logic in_ready,
  output logic out_push,
  output logic out_last,
  output fft_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_LOAD, S_ZERO, S_PERM, S_BF_RA, S_BF_RB, S_BF_WAIT, S_BF_WR, S_OUT
  } state_t;

  state_t state_r;
  logic [6:0] cnt_r;
  logic [2:0] k_r;
  logic inv_r;
  logic [2:0] lvl_r;
  logic [5:0] grp_r;
  logic [5:0] pi_r;
  logic [1:0] ph_r;
  logic ov_r;
  logic [6:0] n_w;
  logic [6:0] n_eff;
  logic [2:0] k_eff;
  logic [5:0] rev_w;
  logic [5:0] half_w;
  logic [5:0] jj_w;
  logic [5:0] ia_w;
  logic [5:0] tw_w;

  always_comb begin
    k_eff = size_log2;
    if (k_eff == 3'd0) k_eff = 3'd1;
    if (k_eff > 3'(MaxLog2)) k_eff = 3'(MaxLog2);
  end

  assign n_w = 7'd1 << k_r;
  assign n_eff = 7'd1 << k_eff;

  always_comb begin
    rev_w = '0;
    for (int b = 0; b < MaxLog2; b++) begin
      if (3'(b) < k_r) rev_w[3'(k_r - 3'd1 - 3'(b))] = pi_r[b];
    end
  end

  // Butterfly index: grp_r enumerates n/2 butterflies; low bits pick j.
  assign half_w = 6'd1 << (lvl_r - 3'd1);
  assign jj_w = grp_r & (half_w - 6'd1);
  assign ia_w = ((grp_r & ~(half_w - 6'd1)) << 1) | jj_w;
  assign tw_w = 6'(jj_w << (3'(MaxLog2) - lvl_r));

  always_comb begin
    cmd = '0;
    cmd.load_addr = cnt_r[5:0];
    cmd.shift = inv_r ? k_r : 3'd0;
    cmd.tw_idx = tw_w;
    cmd.addr_a = ia_w;
    cmd.addr_b = ia_w | half_w;
    in_ready = (state_r == S_LOAD);
    out_push = 1'b0;
    out_last = 1'b0;
    case (state_r)
      S_LOAD: begin
        cmd.wr_load = in_fire && (cnt_r < n_eff);
      end
      S_ZERO: begin
        cmd.zero_wr = (cnt_r < n_w);
      end
      S_PERM: begin
        // Read pi, read rev, latch both, then write them back crossed.
        cmd.rd_en = 1'b1;
        cmd.rd_addr = (ph_r == 2'd0) ? pi_r : rev_w;
        cmd.addr_a = pi_r;
        cmd.addr_b = rev_w;
        cmd.sel_b = (ph_r == 2'd1);
        cmd.bfly = (ph_r == 2'd2);
        cmd.wr_a = (ph_r == 2'd3);
        cmd.wr_b = (ph_r == 2'd3);
        cmd.swap = (ph_r == 2'd3);
      end
      S_BF_RA: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = ia_w;
      end
      S_BF_RB: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = ia_w | half_w;
        cmd.sel_b = 1'b1;
      end
      S_BF_WAIT: begin
        cmd.bfly = 1'b1;
      end
      S_BF_WR: begin
        cmd.wr_a = 1'b1;
        cmd.wr_b = 1'b1;
      end
      S_OUT: begin
        cmd.rd_en = !out_busy;
        cmd.rd_addr = pi_r;
        out_push = ov_r;
        out_last = ov_r && (cnt_r == n_w - 7'd1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r <= '0;
      k_r <= 3'd1;
      inv_r <= 1'b0;
      lvl_r <= 3'd1;
      grp_r <= '0;
      pi_r <= '0;
      ph_r <= '0;
      ov_r <= 1'b0;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (in_fire) begin
            if (cnt_r < n_eff) cnt_r <= cnt_r + 7'd1;
            else cnt_r <= n_eff;
            if (in_last) begin
              k_r <= k_eff;
              inv_r <= inverse;
              state_r <= S_ZERO;
            end
          end
        end
        S_ZERO: begin
          // Clear the unfilled tail one entry a cycle.
          if (cnt_r >= n_w) begin
            state_r <= S_PERM;
            pi_r <= '0;
            ph_r <= '0;
          end else begin
            cnt_r <= cnt_r + 7'd1;
          end
        end
        S_PERM: begin
          if (pi_r >= rev_w && ph_r == 2'd0) begin
            if ({1'b0, pi_r} == n_w - 7'd1) begin
              state_r <= S_BF_RA;
              lvl_r <= 3'd1;
              grp_r <= '0;
            end else begin
              pi_r <= pi_r + 6'd1;
            end
          end else if (ph_r == 2'd3) begin
            ph_r <= '0;
            if ({1'b0, pi_r} == n_w - 7'd1) begin
              state_r <= S_BF_RA;
              lvl_r <= 3'd1;
              grp_r <= '0;
            end else begin
              pi_r <= pi_r + 6'd1;
            end
          end else begin
            ph_r <= ph_r + 2'd1;
          end
        end
        S_BF_RA: state_r <= S_BF_RB;
        S_BF_RB: state_r <= S_BF_WAIT;
        S_BF_WAIT: state_r <= S_BF_WR;
        S_BF_WR: begin
          state_r <= S_BF_RA;
          if ({grp_r, 1'b1} == 7'(n_w - 7'd1)) begin
            grp_r <= '0;
            if (lvl_r == k_r) begin
              state_r <= S_OUT;
              pi_r <= '0;
              cnt_r <= '0;
              ov_r <= 1'b0;
            end else begin
              lvl_r <= lvl_r + 3'd1;
            end
          end else begin
            grp_r <= grp_r + 6'd1;
          end
        end
        S_OUT: begin
          if (!out_busy) begin
            if (ov_r) begin
              cnt_r <= cnt_r + 7'd1;
              if (cnt_r == n_w - 7'd1) begin
                state_r <= S_LOAD;
                cnt_r <= '0;
              end
            end
            ov_r <= ({1'b0, pi_r} < n_w) && !(ov_r && cnt_r == n_w - 7'd1);
            pi_r <= pi_r + 6'd1;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule

// ===== rtl/core/fft_dpath.sv =====
module fft_dpath
  import fft_pkg::*;
(
  input  logic clk,
  input  in_item_t in_item,
  input  logic inverse,
  input  fft_cmd_t cmd,
  output logic signed [DataW-1:0] rd_re,
  output logic signed [DataW-1:0] rd_im
);

  logic signed [DataW-1:0] mem_re [MaxPoints];
  logic signed [DataW-1:0] mem_im [MaxPoints];
  logic signed [DataW-1:0] q_re_r, q_im_r;
  logic signed [DataW-1:0] a_re_r, a_im_r, b_re_r, b_im_r;
  logic signed [43:0] m_re_r, m_im_r;
  logic signed [DataW-1:0] wa_re, wa_im, wb_re, wb_im;
  logic signed [DataW-1:0] t_re, t_im;
  logic signed [DataW-1:0] ld_re, ld_im;
  logic signed [TwW-1:0] c_w, s_w;
  logic signed [41:0] p_cr, p_si, p_ci, p_sr;
  logic signed [43:0] sum_re, sum_im;

  assign c_w = rom_cos(cmd.tw_idx);
  assign s_w = inverse ? rom_cos(6'(cmd.tw_idx + 6'd48))
                       : -rom_cos(6'(cmd.tw_idx + 6'd48));

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      q_re_r <= mem_re[cmd.rd_addr];
      q_im_r <= mem_im[cmd.rd_addr];
    end
  end

  // Hold operands: first read lands as A, second as B.
  always_ff @(posedge clk) begin
    if (cmd.sel_b) begin
      a_re_r <= q_re_r;
      a_im_r <= q_im_r;
    end
    if (cmd.bfly) begin
      b_re_r <= q_re_r;
      b_im_r <= q_im_r;
    end
  end

  assign p_cr = 42'(c_w) * 42'(q_re_r);
  assign p_si = 42'(s_w) * 42'(q_im_r);
  assign p_ci = 42'(c_w) * 42'(q_im_r);
  assign p_sr = 42'(s_w) * 42'(q_re_r);
  assign sum_re = 44'(p_cr) - 44'(p_si) + 44'sd65536;
  assign sum_im = 44'(p_ci) + 44'(p_sr) + 44'sd65536;

  always_ff @(posedge clk) begin
    if (cmd.bfly) begin
      m_re_r <= sum_re >>> TwFrac;
      m_im_r <= sum_im >>> TwFrac;
    end
  end

  assign t_re = m_re_r[DataW-1:0];
  assign t_im = m_im_r[DataW-1:0];

  assign wa_re = a_re_r + t_re;
  assign wa_im = a_im_r + t_im;
  assign wb_re = a_re_r - t_re;
  assign wb_im = a_im_r - t_im;

  assign ld_re = cmd.wr_load ? DataW'(in_item.sample_re) : '0;
  assign ld_im = cmd.wr_load ? DataW'(in_item.sample_im) : '0;

  always_ff @(posedge clk) begin
    if (cmd.wr_load || cmd.zero_wr) begin
      mem_re[cmd.load_addr] <= ld_re;
      mem_im[cmd.load_addr] <= ld_im;
    end else begin
      // Permutation swap or butterfly write; in a swap, A came from addr_a, B from addr_b.
      if (cmd.wr_a) begin
        mem_re[cmd.addr_a] <= cmd.swap ? b_re_r : wa_re;
        mem_im[cmd.addr_a] <= cmd.swap ? b_im_r : wa_im;
      end
      if (cmd.wr_b) begin
        mem_re[cmd.addr_b] <= cmd.swap ? a_re_r : wb_re;
        mem_im[cmd.addr_b] <= cmd.swap ? a_im_r : wb_im;
      end
    end
  end

  assign rd_re = q_re_r >>> cmd.shift;
  assign rd_im = q_im_r >>> cmd.shift;

endmodule
